// ===== rtl/gds_pkg.sv =====
package gds_pkg;

  localparam int DIST_MAX_W = 21;
  localparam int DIFF_MAX_W = 22;
  localparam int LINE_W = 12;
  localparam int COL_W = 8;
  localparam int SHADE_W = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [LINE_W-1:0] LINE_COUNT_RESET = 12'd256;
  localparam logic [LINE_W-1:0] MIN_LINES = 12'd2;
  localparam logic [SHADE_W-1:0] SHADE_MAX = 8'd255;
  localparam int SHADE_SCALE_SQ = 260100;

  typedef struct packed {
    logic [DIST_MAX_W-1:0]        center;
    logic signed [DIFF_MAX_W-1:0] hdiff;
    logic                         hsp1;
    logic signed [DIFF_MAX_W-1:0] vdiff;
    logic                         vsp1;
    logic [LINE_W-1:0]            line;
    logic [COL_W-1:0]             column;
    logic                         last;
  } job_t;

endpackage

// ===== rtl/gds_if.sv =====
interface gds_in_if #(
  parameter int DIST_W = 17
) ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;

  modport source(output valid, output distance, input ready);
  modport sink(input valid, input distance, output ready);
endinterface

interface gds_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] gradient_shade;
  logic [7:0] depth_shade;
  logic [11:0] out_line;
  logic [7:0] out_column;
  logic       last_of_run;

  modport source(output valid, output gradient_shade, output depth_shade, output out_line,
                 output out_column, output last_of_run, input ready);
  modport sink(input valid, input gradient_shade, input depth_shade, input out_line,
               input out_column, input last_of_run, output ready);
endinterface

// ===== rtl/gds_ram.sv =====
module gds_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gds_queue.sv =====
module gds_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  gds_pkg::job_t push_job_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output gds_pkg::job_t pop_job_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [CNTW-1:0] FULL = CNTW'(DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  gds_pkg::job_t  slot_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != FULL);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = slot_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == LAST_SLOT) ? '0 : wr_q + PW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == LAST_SLOT) ? '0 : rd_q + PW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_job_i;
    end
  end

endmodule

// ===== rtl/gds_front.sv =====
module gds_front #(
  parameter int LINE_WIDTH = 256,
  parameter int FRACTION_BITS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  gds_in_if.sink        in_i,
  input  logic          cfg_we_i,
  input  logic [11:0]   cfg_data_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output gds_pkg::job_t push_job_o
);

  localparam int DW = FRACTION_BITS + 9;
  localparam int CW = $clog2(LINE_WIDTH);
  localparam int ADW = $clog2(2 * LINE_WIDTH);
  localparam int LW = gds_pkg::LINE_W;
  localparam int DFW = gds_pkg::DIFF_MAX_W;
  localparam int CTW = gds_pkg::DIST_MAX_W;
  localparam int COLW = gds_pkg::COL_W;
  localparam logic [DW-1:0] NO_SURF = DW'(256) << FRACTION_BITS;
  localparam logic [CW-1:0] LAST_COL = CW'(LINE_WIDTH - 1);

  localparam logic [2:0] RD_PRV_LEFT = 3'd0;
  localparam logic [2:0] RD_PRV_MID = 3'd1;
  localparam logic [2:0] RD_PRV_RIGHT = 3'd2;
  localparam logic [2:0] RD_CUR_OLD = 3'd3;
  localparam logic [2:0] RD_CUR_LEFT = 3'd4;
  localparam logic [2:0] RD_LAST = 3'd6;
  localparam int NRD = 6;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_READ = 3'b010,
    F_EMIT = 3'b100
  } fstate_e;

  fstate_e         state_q, state_d;
  logic [CW-1:0]   col_q, col_d, icol_q, icol_d;
  logic [LW-1:0]   row_q, row_d, irow_q, irow_d, lc_q, lines;
  logic            sel_q, sel_d, isel_q, isel_d, ilast_q, ilast_d, is_last;
  logic [DW-1:0]   dist_q, dist_d, in_dist;
  logic [2:0]      step_q, step_d, pend_q, pend_d;
  logic [DW-1:0]   rd_q [NRD];
  logic [DW-1:0]   rdata;
  logic [ADW-1:0]  raddr, waddr;
  logic            we;
  logic [CW-1:0]   cm1, cp1, cm2;
  logic [DW-1:0]   pl, pc, pr, co, cl, cll;
  gds_pkg::job_t   job0, job1, job2;

  function automatic logic [ADW-1:0] addr_of(input logic bsel, input logic [CW-1:0] c);
    return bsel ? ADW'(LINE_WIDTH) + ADW'(c) : ADW'(c);
  endfunction

  function automatic logic signed [DFW-1:0] diff(input logic [DW-1:0] a,
                                                 input logic [DW-1:0] b);
    logic signed [DW:0] t;
    t = $signed({1'b0, a}) - $signed({1'b0, b});
    return DFW'(t);
  endfunction

  gds_ram #(
    .WIDTH(DW),
    .DEPTH(2 * LINE_WIDTH)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(dist_q),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign in_i.ready = (state_q == F_IDLE);
  assign in_dist = (in_i.distance > NO_SURF) ? NO_SURF : in_i.distance;
  assign lines = (lc_q < gds_pkg::MIN_LINES) ? gds_pkg::MIN_LINES : lc_q;
  assign is_last = ((LW + 1)'(row_q) + (LW + 1)'(1)) >= (LW + 1)'(lines);

  assign cm1 = (icol_q == '0) ? '0 : icol_q - CW'(1);
  assign cp1 = (icol_q == LAST_COL) ? icol_q : icol_q + CW'(1);
  assign cm2 = (icol_q < CW'(2)) ? '0 : icol_q - CW'(2);

  assign pl  = rd_q[5];
  assign pc  = rd_q[4];
  assign pr  = rd_q[3];
  assign co  = rd_q[2];
  assign cl  = rd_q[1];
  assign cll = rd_q[0];

  assign we = (state_q == F_READ) && (step_q == RD_LAST);
  assign waddr = addr_of(isel_q, icol_q);

  always_comb begin
    case (step_q)
      RD_PRV_LEFT:  raddr = addr_of(!isel_q, cm1);
      RD_PRV_MID:   raddr = addr_of(!isel_q, icol_q);
      RD_PRV_RIGHT: raddr = addr_of(!isel_q, cp1);
      RD_CUR_OLD:   raddr = addr_of(isel_q, icol_q);
      RD_CUR_LEFT:  raddr = addr_of(isel_q, cm1);
      default:      raddr = addr_of(isel_q, cm2);
    endcase
  end

  // Pixel of the line above, with its lower neighbor just arrived.
  always_comb begin
    job0 = '0;
    job0.center = CTW'(pc);
    if (icol_q == '0) begin
      job0.hdiff = diff(pc, pr);
      job0.hsp1  = 1'b1;
    end else if (icol_q == LAST_COL) begin
      job0.hdiff = diff(pc, pl);
      job0.hsp1  = 1'b1;
    end else begin
      job0.hdiff = diff(pl, pr);
      job0.hsp1  = 1'b0;
    end
    if (irow_q == LW'(1)) begin
      job0.vdiff = diff(pc, dist_q);
      job0.vsp1  = 1'b1;
    end else begin
      job0.vdiff = diff(co, dist_q);
      job0.vsp1  = 1'b0;
    end
    job0.line   = irow_q - LW'(1);
    job0.column = COLW'(icol_q);
  end

  // Bottom line: the pixel to the left of the new one, and the final pixel.
  always_comb begin
    job1 = '0;
    job1.center = CTW'(cl);
    if (icol_q == CW'(1)) begin
      job1.hdiff = diff(cl, dist_q);
      job1.hsp1  = 1'b1;
    end else begin
      job1.hdiff = diff(cll, dist_q);
      job1.hsp1  = 1'b0;
    end
    job1.vdiff  = diff(pl, cl);
    job1.vsp1   = 1'b1;
    job1.line   = irow_q;
    job1.column = COLW'(icol_q - CW'(1));

    job2 = '0;
    job2.center = CTW'(dist_q);
    job2.hdiff  = diff(dist_q, cl);
    job2.hsp1   = 1'b1;
    job2.vdiff  = diff(pc, dist_q);
    job2.vsp1   = 1'b1;
    job2.line   = irow_q;
    job2.column = COLW'(icol_q);
  end

  always_comb begin
    if (pend_q[0]) begin
      push_job_o = job0;
    end else if (pend_q[1]) begin
      push_job_o = job1;
    end else begin
      push_job_o = job2;
    end
    push_job_o.last = ((pend_q & (pend_q - 3'd1)) == 3'd0);
  end

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    sel_d   = sel_q;
    dist_d  = dist_q;
    icol_d  = icol_q;
    irow_d  = irow_q;
    isel_d  = isel_q;
    ilast_d = ilast_q;
    step_d  = step_q;
    pend_d  = pend_q;
    push_valid_o = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        if (in_i.valid) begin
          dist_d  = in_dist;
          icol_d  = col_q;
          irow_d  = row_q;
          isel_d  = sel_q;
          ilast_d = is_last;
          step_d  = '0;
          state_d = F_READ;
          if (col_q == LAST_COL) begin
            col_d = '0;
            sel_d = !sel_q;
            row_d = is_last ? '0 : row_q + LW'(1);
          end else begin
            col_d = col_q + CW'(1);
          end
        end
      end
      F_READ: begin
        step_d = step_q + 3'd1;
        if (step_q == RD_LAST) begin
          pend_d = {ilast_q && (icol_q == LAST_COL), ilast_q && (icol_q != '0),
                    irow_q != '0};
          state_d = F_EMIT;
        end
      end
      F_EMIT: begin
        if (pend_q == 3'd0) begin
          state_d = F_IDLE;
        end else begin
          push_valid_o = 1'b1;
          if (push_ready_i) begin
            pend_d = pend_q & (pend_q - 3'd1);
          end
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      sel_q   <= 1'b0;
      lc_q    <= gds_pkg::LINE_COUNT_RESET;
      pend_q  <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      sel_q   <= sel_d;
      pend_q  <= pend_d;
      step_q  <= step_d;
      if (cfg_we_i) begin
        lc_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q  <= dist_d;
    icol_q  <= icol_d;
    irow_q  <= irow_d;
    isel_q  <= isel_d;
    ilast_q <= ilast_d;
    if (state_q == F_READ && step_q != '0) begin
      rd_q[0] <= rdata;
      for (int i = 1; i < NRD; i++) begin
        rd_q[i] <= rd_q[i-1];
      end
    end
  end

endmodule

// ===== rtl/gds_back.sv =====
module gds_back #(
  parameter int FRACTION_BITS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  gds_pkg::job_t pop_job_i,
  gds_out_if.source     out_o
);

  localparam int AW = FRACTION_BITS + 10;
  localparam int QW = 2 * AW;
  localparam int QLW = QW / 2;
  localparam int QHW = QW - QLW;
  localparam int TW = 18;
  localparam int PW = QW + TW;
  localparam int DFW = gds_pkg::DIFF_MAX_W;
  localparam int CTW = gds_pkg::DIST_MAX_W;
  localparam int SW = gds_pkg::SHADE_W;
  localparam logic [QW-1:0] K_SQ = QW'(1) << (2 * FRACTION_BITS + 2);
  localparam logic [PW-1:0] LIMIT = PW'(gds_pkg::SHADE_SCALE_SQ) << (2 * FRACTION_BITS + 2);
  localparam logic [CTW-1:0] NO_SURF = CTW'(256) << FRACTION_BITS;
  localparam logic [CTW:0] ROUND_UP = (CTW + 1)'((1 << FRACTION_BITS) - 1);

  typedef enum logic [8:0] {
    B_IDLE = 9'b000000001,
    B_ABS  = 9'b000000010,
    B_SQH  = 9'b000000100,
    B_SQV  = 9'b000001000,
    B_SQ   = 9'b000010000,
    B_LO   = 9'b000100000,
    B_HI   = 9'b001000000,
    B_CMP  = 9'b010000000,
    B_DONE = 9'b100000000
  } bstate_e;

  bstate_e          state_q, state_d;
  gds_pkg::job_t    job_q, job_d;
  logic [AW-1:0]    ha_q, ha_d, va_q, va_d, sq_in;
  logic [QW-1:0]    q_q, q_d, sq;
  logic [SW-1:0]    res_q, res_d, trial;
  logic [2:0]       bit_q, bit_d;
  logic [TW-1:0]    t2_q, t2_d;
  logic [SW:0]      t9;
  logic [TW+QLW-1:0] plo_q, plo_d;
  logic [TW+QHW-1:0] phi_q, phi_d;
  logic [PW-1:0]    prod;
  logic [DFW-1:0]   hmag, vmag;
  logic [CTW:0]     up_sum;
  logic [SW:0]      up;
  logic [SW-1:0]    depth;
  logic             empty, load;
  logic             ov_q;
  logic [SW-1:0]    og_q, od_q;
  logic [11:0]      ol_q;
  logic [7:0]       oc_q;
  logic             olast_q;

  assign pop_ready_o = (state_q == B_IDLE);

  assign hmag  = job_q.hdiff[DFW-1] ? DFW'(-job_q.hdiff) : DFW'(job_q.hdiff);
  assign vmag  = job_q.vdiff[DFW-1] ? DFW'(-job_q.vdiff) : DFW'(job_q.vdiff);
  assign sq_in = (state_q == B_SQH) ? ha_q : va_q;
  assign sq    = sq_in * sq_in;
  assign trial = res_q | (SW'(1) << bit_q);
  assign t9    = {trial, 1'b0} - (SW + 1)'(1);
  assign prod  = {phi_q, QLW'(0)} + PW'(plo_q);

  assign empty  = (job_q.center >= NO_SURF);
  assign up_sum = (CTW + 1)'(job_q.center) + ROUND_UP;
  assign up     = (SW + 1)'(up_sum >> FRACTION_BITS);
  assign depth  = (up >= (SW + 1)'(gds_pkg::SHADE_MAX)) ? '0
                : SW'((SW + 1)'(gds_pkg::SHADE_MAX) - up);

  assign load = (state_q == B_DONE) && (!ov_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    ha_d    = ha_q;
    va_d    = va_q;
    q_d     = q_q;
    res_d   = res_q;
    bit_d   = bit_q;
    t2_d    = t2_q;
    plo_d   = plo_q;
    phi_d   = phi_q;
    unique case (state_q)
      B_IDLE: begin
        if (pop_valid_i) begin
          job_d   = pop_job_i;
          state_d = B_ABS;
        end
      end
      B_ABS: begin
        ha_d = job_q.hsp1 ? AW'({hmag, 1'b0}) : AW'(hmag);
        va_d = job_q.vsp1 ? AW'({vmag, 1'b0}) : AW'(vmag);
        state_d = B_SQH;
      end
      B_SQH: begin
        q_d = K_SQ + sq;
        state_d = B_SQV;
      end
      B_SQV: begin
        q_d   = q_q + sq;
        res_d = '0;
        bit_d = 3'd7;
        state_d = B_SQ;
      end
      B_SQ: begin
        t2_d = t9 * t9;
        state_d = B_LO;
      end
      B_LO: begin
        plo_d = t2_q * q_q[QLW-1:0];
        state_d = B_HI;
      end
      B_HI: begin
        phi_d = t2_q * q_q[QW-1:QLW];
        state_d = B_CMP;
      end
      B_CMP: begin
        if (prod <= LIMIT) begin
          res_d = trial;
        end
        if (bit_q == 3'd0) begin
          state_d = B_DONE;
        end else begin
          bit_d = bit_q - 3'd1;
          state_d = B_SQ;
        end
      end
      B_DONE: begin
        if (load) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    ha_q  <= ha_d;
    va_q  <= va_d;
    q_q   <= q_d;
    res_q <= res_d;
    bit_q <= bit_d;
    t2_q  <= t2_d;
    plo_q <= plo_d;
    phi_q <= phi_d;
    if (load) begin
      og_q    <= empty ? '0 : res_q;
      od_q    <= empty ? '0 : depth;
      ol_q    <= job_q.line;
      oc_q    <= job_q.column;
      olast_q <= job_q.last;
    end
  end

  assign out_o.valid          = ov_q;
  assign out_o.gradient_shade = og_q;
  assign out_o.depth_shade    = od_q;
  assign out_o.out_line       = ol_q;
  assign out_o.out_column     = oc_q;
  assign out_o.last_of_run    = olast_q;

endmodule

// ===== rtl/gradient_depth_shading.sv =====
// Gradient and depth shading of a depth map streamed in raster order.
// Input channel in_i carries one distance word per pixel (unsigned, FRACTION_BITS
// fraction bits; 256.0 or more means no surface). Output channel out_o carries one
// word per shaded pixel: gradient shade, depth shade, line, column and a flag on the
// final word caused by each input word. cfg_we_i writes the line count from cfg_data_i.
// A pixel is shaded once the pixel below it has arrived; on the last line the line
// itself is flushed, so one input word causes zero to three output words.
// The front part accepts an input word, reads the line store, writes the new word,
// hands its queued jobs over one at a time and then returns to idle; it takes no new
// input word until it is back in idle.
// The back part computes each output word by an eight-step search for the inverse
// square root; each step squares a trial value, multiplies it with the sum of squares
// in a low and a high half, and compares the product with the limit. It takes a new
// job from the queue only after its result has gone to the output register.
// A four-entry job queue and an output register let both sides stall on their own;
// when the receiver stalls, the output word holds, the queue fills, and in_i.ready drops.
// Reset clears the line, column and buffer counters, sets the line count to 256 and
// empties the queue; the line store needs no clearing since each entry is written
// before it is read.
module gradient_depth_shading #(
  parameter int LINE_WIDTH = 256,
  parameter int FRACTION_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gds_in_if.sink      in_i,
  gds_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_data_i
);

  logic          q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  gds_pkg::job_t q_push_job, q_pop_job;

  gds_front #(
    .LINE_WIDTH   (LINE_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .push_valid_o(q_push_valid),
    .push_ready_i(q_push_ready),
    .push_job_o  (q_push_job)
  );

  gds_queue #(
    .DEPTH(gds_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(q_push_valid),
    .push_ready_o(q_push_ready),
    .push_job_i  (q_push_job),
    .pop_valid_o (q_pop_valid),
    .pop_ready_i (q_pop_ready),
    .pop_job_o   (q_pop_job)
  );

  gds_back #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(q_pop_valid),
    .pop_ready_o(q_pop_ready),
    .pop_job_i  (q_pop_job),
    .out_o      (out_o)
  );

`ifndef SYNTHESIS
  a_front_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("front accepted two words back to back");

  a_back_one_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_valid && q_pop_ready |=> !q_pop_ready)
    else $error("back took a new job while busy");

  a_no_push_to_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_valid && !q_push_ready |=> q_push_valid && $stable(q_push_job))
    else $error("front dropped a job while the queue was full");
`endif

endmodule
